FILE: src/assert_macros.svh
// Concurrent check helpers, clocked on clock and off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CHECK_IMPLY(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

`define CHECK_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

FILE: src/uvsg_pkg.sv
package uvsg_pkg;

   localparam int SINE_TABLE_DEPTH = 256;
   localparam int MAX_SEGMENTS     = 1024;

   localparam int QTR_W    = $clog2(SINE_TABLE_DEPTH);
   localparam int PHASE_W  = QTR_W + 2;
   localparam int TAB_W    = 15;
   localparam int TRIG_W   = TAB_W + 1;
   localparam int IDX_W    = 10;
   localparam int COUNT_W  = 11;
   localparam int DEN_W    = COUNT_W + 1;
   localparam int RADIUS_W = 16;
   localparam int COORD_W  = 17;
   localparam int SLOT_W   = 3;
   localparam int PROD_W   = 2 * TRIG_W;
   localparam int WIDE_W   = 48;
   localparam int YPROD_W  = RADIUS_W + 1 + TRIG_W;

   localparam int DIV_BITS  = 4;
   localparam int DIV_STEPS = 6;
   localparam int NUM_W     = DIV_BITS * DIV_STEPS;
   localparam int CNT_W     = 3;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(5);

   localparam int CSR_W = 2;
   localparam logic [CSR_W-1:0] CSR_RADIUS      = CSR_W'(0);
   localparam logic [CSR_W-1:0] CSR_SLICE_COUNT = CSR_W'(1);
   localparam logic [CSR_W-1:0] CSR_LAYER_COUNT = CSR_W'(2);

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint          ONE_Q30     = 64'd1073741824;

   typedef logic [TAB_W-1:0] sine_entry_type;
   typedef sine_entry_type sine_tab_type [0:SINE_TABLE_DEPTH];

   typedef struct packed {
      logic [PHASE_W-1:0] beta;
      logic [PHASE_W-1:0] nbeta;
      logic [PHASE_W-1:0] alpha;
      logic [PHASE_W-1:0] nalpha;
   } cell_angles_type;

   function automatic longint unsigned div_floor(input longint unsigned num,
                                                 input longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   function automatic sine_tab_type build_sine_tab();
      sine_tab_type    tab;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
         x    = (HALF_PI_Q30 * longint'(k)) >> QTR_W;
         x2   = (x * x) >> 30;
         term = x;
         sum  = longint'(x);
         for (int n = 1; n <= 9; n++) begin
            term = (term * x2) >> 30;
            term = div_floor(term, 64'((2 * n) * (2 * n + 1)));
            if ((n & 1) != 0) sum = sum - longint'(term);
            else sum = sum + longint'(term);
         end
         if (sum < 0) sum = 0;
         if (sum > ONE_Q30) sum = ONE_Q30;
         tab[k] = TAB_W'((longint'(sum) * 32767 + (64'd1 << 29)) >> 30);
      end
      return tab;
   endfunction

   localparam sine_tab_type SINE_TAB = build_sine_tab();

   function automatic logic signed [TRIG_W-1:0] phase_sine(input logic [PHASE_W-1:0] p);
      logic [QTR_W-1:0] r;
      logic [QTR_W:0]   idx;
      logic [TAB_W-1:0] mag;
      r   = p[QTR_W-1:0];
      idx = p[QTR_W] ? ((QTR_W+1)'(SINE_TABLE_DEPTH) - {1'b0, r}) : {1'b0, r};
      mag = SINE_TAB[idx];
      return p[PHASE_W-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   endfunction

endpackage

FILE: src/uvsg_div.sv
module uvsg_div (
   input  logic                           clock,
   input  logic                           load,
   input  logic                           step,
   input  logic [uvsg_pkg::NUM_W-1:0]     numer,
   input  logic [uvsg_pkg::DEN_W-1:0]     denom,
   output logic [uvsg_pkg::NUM_W-1:0]     quot,
   output logic [uvsg_pkg::NUM_W-1:0]     quot_step
);

   logic [uvsg_pkg::NUM_W-1:0] num_ff, num_in;
   logic [uvsg_pkg::DEN_W-1:0] rem_ff, rem_in;
   logic [uvsg_pkg::DEN_W-1:0] den_ff, den_in;
   logic [uvsg_pkg::NUM_W-1:0] n_w;
   logic [uvsg_pkg::DEN_W-1:0] r_w;
   logic [uvsg_pkg::DEN_W:0]   t_w;

   always_comb begin
      n_w = num_ff;
      r_w = rem_ff;
      for (int i = 0; i < uvsg_pkg::DIV_BITS; i++) begin
         t_w = {r_w, n_w[uvsg_pkg::NUM_W-1]};
         n_w = {n_w[uvsg_pkg::NUM_W-2:0], 1'b0};
         if (t_w >= {1'b0, den_ff}) begin
            t_w = t_w - {1'b0, den_ff};
            n_w[0] = 1'b1;
         end
         r_w = t_w[uvsg_pkg::DEN_W-1:0];
      end
      quot_step = n_w;
      num_in = num_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      if (load) begin
         num_in = numer;
         rem_in = '0;
         den_in = denom;
      end else if (step) begin
         num_in = n_w;
         rem_in = r_w;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quot = num_ff;

endmodule

FILE: src/uvsg_front.sv
`include "assert_macros.svh"

module uvsg_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [23:0]                       req_tdata,
   input  logic [uvsg_pkg::COUNT_W-1:0]      slice_count,
   input  logic [uvsg_pkg::COUNT_W-1:0]      layer_count,
   output logic                              push,
   input  logic                              push_ready,
   output uvsg_pkg::cell_angles_type         push_data
);

   localparam logic [uvsg_pkg::COUNT_W-1:0] MAX_C = uvsg_pkg::COUNT_W'(uvsg_pkg::MAX_SEGMENTS);
   localparam logic [uvsg_pkg::PHASE_W-1:0] BETA_OFS =
      uvsg_pkg::PHASE_W'(3 * uvsg_pkg::SINE_TABLE_DEPTH);
   localparam logic [uvsg_pkg::CNT_W-1:0] LAST_STEP = uvsg_pkg::CNT_W'(uvsg_pkg::DIV_STEPS - 1);

   logic                              busy_ff, busy_in;
   logic [uvsg_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic [uvsg_pkg::IDX_W-1:0]        li, si;
   logic [uvsg_pkg::COUNT_W-1:0]      nl, ns;
   logic [uvsg_pkg::DEN_W-1:0]        den_b, den_a;
   logic [uvsg_pkg::NUM_W-1:0]        num_b, num_nb, num_a, num_na;
   logic [uvsg_pkg::NUM_W-1:0]        q_b, q_nb, q_a, q_na;
   logic [uvsg_pkg::NUM_W-1:0]        qs_b, qs_nb, qs_a, qs_na;
   logic                              accept, done, step, at_last;

   assign li = req_tdata[uvsg_pkg::IDX_W-1:0];
   assign si = req_tdata[2*uvsg_pkg::IDX_W-1:uvsg_pkg::IDX_W];

   always_comb begin
      nl = (layer_count == '0) ? uvsg_pkg::COUNT_W'(1) :
           (layer_count > MAX_C) ? MAX_C : layer_count;
      ns = (slice_count == '0) ? uvsg_pkg::COUNT_W'(1) :
           (slice_count > MAX_C) ? MAX_C : slice_count;
      den_b  = {nl, 1'b0};
      den_a  = {ns, 1'b0};
      num_b  = (uvsg_pkg::NUM_W'(li) << uvsg_pkg::PHASE_W) + uvsg_pkg::NUM_W'(nl);
      num_nb = ((uvsg_pkg::NUM_W'(li) + uvsg_pkg::NUM_W'(1)) << uvsg_pkg::PHASE_W)
               + uvsg_pkg::NUM_W'(nl);
      num_a  = (uvsg_pkg::NUM_W'(si) << (uvsg_pkg::PHASE_W + 1)) + uvsg_pkg::NUM_W'(ns);
      num_na = ((uvsg_pkg::NUM_W'(si) + uvsg_pkg::NUM_W'(1)) << (uvsg_pkg::PHASE_W + 1))
               + uvsg_pkg::NUM_W'(ns);
   end

   assign at_last    = (cnt_ff == LAST_STEP);
   assign done       = busy_ff && (cnt_ff >= LAST_STEP);
   assign step       = busy_ff && (cnt_ff <= LAST_STEP);
   assign push       = done;
   assign req_tready = !busy_ff || (done && push_ready);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      push_data.beta   = (at_last ? qs_b[uvsg_pkg::PHASE_W-1:0] : q_b[uvsg_pkg::PHASE_W-1:0])
                         + BETA_OFS;
      push_data.nbeta  = (at_last ? qs_nb[uvsg_pkg::PHASE_W-1:0] : q_nb[uvsg_pkg::PHASE_W-1:0])
                         + BETA_OFS;
      push_data.alpha  = at_last ? qs_a[uvsg_pkg::PHASE_W-1:0] : q_a[uvsg_pkg::PHASE_W-1:0];
      push_data.nalpha = at_last ? qs_na[uvsg_pkg::PHASE_W-1:0] : q_na[uvsg_pkg::PHASE_W-1:0];
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      if (step && !at_last) cnt_in = cnt_ff + uvsg_pkg::CNT_W'(1);
      if (step && at_last) cnt_in = LAST_STEP + uvsg_pkg::CNT_W'(1);
      if (done && push_ready) busy_in = 1'b0;
      if (accept) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   uvsg_div u_div_b  (.clock, .load(accept), .step, .numer(num_b),  .denom(den_b),
                      .quot(q_b),  .quot_step(qs_b));
   uvsg_div u_div_nb (.clock, .load(accept), .step, .numer(num_nb), .denom(den_b),
                      .quot(q_nb), .quot_step(qs_nb));
   uvsg_div u_div_a  (.clock, .load(accept), .step, .numer(num_a),  .denom(den_a),
                      .quot(q_a),  .quot_step(qs_a));
   uvsg_div u_div_na (.clock, .load(accept), .step, .numer(num_na), .denom(den_a),
                      .quot(q_na), .quot_step(qs_na));

   `CHECK_IMPLY(a_push_after_steps, push, cnt_ff >= LAST_STEP, "push before divide done")

endmodule

FILE: src/uvsg_queue.sv
`include "assert_macros.svh"

module uvsg_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   output logic                       push_ready,
   input  uvsg_pkg::cell_angles_type  push_data,
   output logic                       pop_valid,
   input  logic                       pop,
   output uvsg_pkg::cell_angles_type  pop_data
);

   uvsg_pkg::cell_angles_type mem_ff [0:1];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = mem_ff[rd_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_in    = do_push ? !wr_ff : wr_ff;
      rd_in    = do_pop ? !rd_ff : rd_ff;
      count_in = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ff] <= push_data;
   end

   `CHECK_IMPLY(a_count_ptrs, count_ff == 2'd0 || count_ff == 2'd2, wr_ff == rd_ff,
                "queue pointers out of step")

endmodule

FILE: src/uvsg_back.sv
`include "assert_macros.svh"

module uvsg_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               pop_valid,
   output logic                               pop,
   input  uvsg_pkg::cell_angles_type          pop_data,
   input  logic [uvsg_pkg::RADIUS_W-1:0]      radius,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [55:0]                        rsp_tdata,
   output logic                               rsp_tlast
);

   localparam logic [uvsg_pkg::PHASE_W-1:0] QTR = uvsg_pkg::PHASE_W'(uvsg_pkg::SINE_TABLE_DEPTH);

   logic                                      en, take;
   logic [uvsg_pkg::SLOT_W-1:0]               slot_ff, slot_in;
   logic [uvsg_pkg::PHASE_W-1:0]              pb, pa;

   logic [3:0]                                v_ff, v_in;
   logic [uvsg_pkg::SLOT_W-1:0]               s1_slot_ff, s2_slot_ff, s3_slot_ff, o_slot_ff;
   logic signed [uvsg_pkg::TRIG_W-1:0]        sb_ff, cb_ff, sa_ff, ca_ff;
   logic signed [uvsg_pkg::PROD_W-1:0]        px_ff, pz_ff;
   logic signed [uvsg_pkg::YPROD_W-1:0]       py_ff;
   logic signed [uvsg_pkg::WIDE_W-1:0]        wx_ff, wz_ff, wy_ff;
   logic signed [uvsg_pkg::COORD_W-1:0]       ox_ff, oy_ff, oz_ff;
   logic signed [uvsg_pkg::RADIUS_W:0]        rad_s;
   logic signed [uvsg_pkg::RADIUS_W+uvsg_pkg::PROD_W:0] mx, mz;

   function automatic logic signed [uvsg_pkg::COORD_W-1:0] round_shift(
      input logic signed [uvsg_pkg::WIDE_W-1:0] v, input int sh);
      logic [uvsg_pkg::WIDE_W-1:0] m;
      m = v[uvsg_pkg::WIDE_W-1] ? uvsg_pkg::WIDE_W'(-v) : uvsg_pkg::WIDE_W'(v);
      m = (m + (uvsg_pkg::WIDE_W'(1) << (sh - 1))) >> sh;
      return v[uvsg_pkg::WIDE_W-1] ? -$signed(uvsg_pkg::COORD_W'(m))
                                   : $signed(uvsg_pkg::COORD_W'(m));
   endfunction

   assign en    = !v_ff[3] || rsp_tready;
   assign take  = en && pop_valid;
   assign pop   = take && (slot_ff == uvsg_pkg::LAST_SLOT);
   assign rad_s = $signed({1'b0, radius});

   always_comb begin
      pb = (slot_ff inside {3'd0, 3'd2, 3'd3}) ? pop_data.nbeta : pop_data.beta;
      pa = (slot_ff inside {3'd2, 3'd3, 3'd5}) ? pop_data.nalpha : pop_data.alpha;
      slot_in = slot_ff;
      if (take) slot_in = (slot_ff == uvsg_pkg::LAST_SLOT) ? '0 : slot_ff + uvsg_pkg::SLOT_W'(1);
      v_in = en ? {v_ff[2:0], pop_valid} : v_ff;
      mx = rad_s * px_ff;
      mz = rad_s * pz_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         v_ff    <= '0;
      end else begin
         slot_ff <= slot_in;
         v_ff    <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_slot_ff <= slot_ff;
         sb_ff      <= uvsg_pkg::phase_sine(pb);
         cb_ff      <= uvsg_pkg::phase_sine(pb + QTR);
         sa_ff      <= uvsg_pkg::phase_sine(pa);
         ca_ff      <= uvsg_pkg::phase_sine(pa + QTR);
         s2_slot_ff <= s1_slot_ff;
         px_ff      <= sa_ff * cb_ff;
         pz_ff      <= cb_ff * ca_ff;
         py_ff      <= rad_s * sb_ff;
         s3_slot_ff <= s2_slot_ff;
         wx_ff      <= mx[uvsg_pkg::WIDE_W-1:0];
         wz_ff      <= mz[uvsg_pkg::WIDE_W-1:0];
         wy_ff      <= uvsg_pkg::WIDE_W'(py_ff);
         o_slot_ff  <= s3_slot_ff;
         ox_ff      <= round_shift(wx_ff, 30);
         oy_ff      <= round_shift(wy_ff, 15);
         oz_ff      <= round_shift(wz_ff, 30);
      end
   end

   assign rsp_tvalid = v_ff[3];
   assign rsp_tlast  = (o_slot_ff == uvsg_pkg::LAST_SLOT);
   assign rsp_tdata  = {2'b00, o_slot_ff, oz_ff, oy_ff, ox_ff};

   `CHECK_IMPLY(a_pop_on_last, pop, slot_ff == uvsg_pkg::LAST_SLOT, "pop before sixth vertex")
   `CHECK_NEXT(a_slot_wrap, take && slot_ff == uvsg_pkg::LAST_SLOT, slot_ff == '0,
               "slot did not wrap")

endmodule

FILE: src/uv_sphere_vertex_generator_unit.sv
// channel   dir  handshake            payload
// req       in   req_tvalid/tready    tdata: layer_index, slice_index
// rsp       out  rsp_tvalid/tready    tdata: coord_x, coord_y, coord_z, vertex_slot; tlast
// csr       in   csr_valid/ready      csr_index, csr_data
// Four radix-16 angle dividers in the front make each cell; the next request waits for its push.
// The back emits one vertex per cycle while rsp is ready and the queue holds a cell.
// Reset is synchronous; registers return to radius 1.0 and 16 by 16 segments.
// A stalled rsp holds the back pipeline; the front keeps working until the queue fills.
module uv_sphere_vertex_generator_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [23:0]                       req_tdata,   // layer_index, slice_index
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [55:0]                       rsp_tdata,   // coord_x, coord_y, coord_z, vertex_slot
   output logic                              rsp_tlast,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [uvsg_pkg::CSR_W-1:0]        csr_index,
   input  logic [31:0]                       csr_data
);

   logic [uvsg_pkg::RADIUS_W-1:0] radius_ff, radius_in;
   logic [uvsg_pkg::COUNT_W-1:0]  slices_ff, slices_in;
   logic [uvsg_pkg::COUNT_W-1:0]  layers_ff, layers_in;
   logic                          push, push_ready, pop_valid, pop;
   uvsg_pkg::cell_angles_type     push_data, pop_data;

   assign csr_ready = 1'b1;

   always_comb begin
      radius_in = radius_ff;
      slices_in = slices_ff;
      layers_in = layers_ff;
      if (csr_valid) begin
         case (csr_index)
            uvsg_pkg::CSR_RADIUS:      radius_in = csr_data[uvsg_pkg::RADIUS_W-1:0];
            uvsg_pkg::CSR_SLICE_COUNT: slices_in = csr_data[uvsg_pkg::COUNT_W-1:0];
            uvsg_pkg::CSR_LAYER_COUNT: layers_in = csr_data[uvsg_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= uvsg_pkg::RADIUS_W'(256);
         slices_ff <= uvsg_pkg::COUNT_W'(16);
         layers_ff <= uvsg_pkg::COUNT_W'(16);
      end else begin
         radius_ff <= radius_in;
         slices_ff <= slices_in;
         layers_ff <= layers_in;
      end
   end

   uvsg_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .slice_count(slices_ff), .layer_count(layers_ff),
      .push, .push_ready, .push_data
   );

   uvsg_queue u_queue (
      .clock, .reset, .push, .push_ready, .push_data, .pop_valid, .pop, .pop_data
   );

   uvsg_back u_back (
      .clock, .reset, .pop_valid, .pop, .pop_data, .radius(radius_ff),
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast
   );

endmodule
